@@ rtl/refr_pkg.sv @@
package refr_pkg;

  // vector format
  localparam int VEC_FRAC_BITS = 14;
  localparam int VEC_W         = 16;
  localparam int IDX_W         = 14;
  localparam int ONE           = 1 << VEC_FRAC_BITS;

  // square-root unit: two input bits and one root bit per stage
  localparam int SQ_IN_W   = 36;
  localparam int SQ_OUT_W  = SQ_IN_W / 2;
  localparam int SQ_REM_W  = SQ_OUT_W + 3;
  localparam int SQ_STAGES = SQ_OUT_W;

  // divider unit: one quotient bit per stage, quotient known to fit
  localparam int DV_DEN_W  = 18;
  localparam int DV_Q_W    = 15;
  localparam int DV_NUM_W  = DV_DEN_W + DV_Q_W;
  localparam int DV_STAGES = DV_Q_W;

  // one squared in the wide radicand format
  localparam logic [SQ_IN_W-1:0] ONE2 = SQ_IN_W'(1) << (2 * VEC_FRAC_BITS);

  typedef struct packed {
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] dir_z;
    logic signed [VEC_W-1:0] norm_x;
    logic signed [VEC_W-1:0] norm_y;
    logic signed [VEC_W-1:0] norm_z;
    logic [IDX_W-1:0]        index_incident;
    logic [IDX_W-1:0]        index_transmit;
  } refr_in_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] out_x;
    logic signed [VEC_W-1:0] out_y;
    logic signed [VEC_W-1:0] out_z;
    logic                    total_reflect;
  } refr_out_t;

  // shift right by the fraction width, round to nearest, ties away from zero
  function automatic logic signed [39:0] rnd_shr(input logic signed [39:0] x);
    logic [39:0] mag;
    mag = x[39] ? 40'(-x) : 40'(x);
    mag = (mag + (40'd1 << (VEC_FRAC_BITS - 1))) >> VEC_FRAC_BITS;
    return x[39] ? -$signed(mag) : $signed(mag);
  endfunction

  // clamp to the 16 bit output range
  function automatic logic signed [VEC_W-1:0] sat16(input logic signed [19:0] x);
    logic signed [VEC_W-1:0] res;
    if (x > 20'sd32767) begin
      res = 16'sh7fff;
    end else if (x < -20'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = x[VEC_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ rtl/refr_isqrt.sv @@
module refr_isqrt (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [refr_pkg::SQ_IN_W-1:0]  val_i,
  output logic [refr_pkg::SQ_OUT_W-1:0] root_o
);
  import refr_pkg::*;

  logic [SQ_REM_W-1:0] rem_q  [SQ_STAGES];
  logic [SQ_OUT_W-1:0] root_q [SQ_STAGES];
  logic [SQ_IN_W-1:0]  rad_q  [SQ_STAGES];
  logic [SQ_REM_W-1:0] rem_d  [SQ_STAGES];
  logic [SQ_OUT_W-1:0] root_d [SQ_STAGES];
  logic [SQ_IN_W-1:0]  rad_d  [SQ_STAGES];

  // one root bit per stage, each stage fed by the previous register
  always_comb begin
    logic [SQ_REM_W-1:0] rin;
    logic [SQ_OUT_W-1:0] oin;
    logic [SQ_IN_W-1:0]  ain;
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        rin = '0;
        oin = '0;
        ain = val_i;
      end else begin
        rin = rem_q[k-1];
        oin = root_q[k-1];
        ain = rad_q[k-1];
      end
      cur   = {rin[SQ_OUT_W:0], ain[SQ_IN_W-1 -: 2]};
      trial = {1'b0, oin, 2'b01};
      if (cur >= trial) begin
        rem_d[k]  = cur - trial;
        root_d[k] = {oin[SQ_OUT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = cur;
        root_d[k] = {oin[SQ_OUT_W-2:0], 1'b0};
      end
      rad_d[k] = ain << 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQ_STAGES; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
      end
    end
  end

  assign root_o = root_q[SQ_STAGES-1];

endmodule

@@ rtl/refr_div.sv @@
module refr_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [refr_pkg::DV_NUM_W-1:0] num_i,
  input  logic [refr_pkg::DV_DEN_W-1:0] den_i,
  output logic [refr_pkg::DV_Q_W-1:0]   quo_o
);
  import refr_pkg::*;

  logic [DV_DEN_W-1:0] rem_q [DV_STAGES];
  logic [DV_DEN_W-1:0] den_q [DV_STAGES];
  logic [DV_Q_W-1:0]   low_q [DV_STAGES];
  logic [DV_Q_W-1:0]   quo_q [DV_STAGES];
  logic [DV_DEN_W-1:0] rem_d [DV_STAGES];
  logic [DV_Q_W-1:0]   low_d [DV_STAGES];
  logic [DV_Q_W-1:0]   quo_d [DV_STAGES];
  logic [DV_DEN_W-1:0] den_d [DV_STAGES];

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [DV_DEN_W-1:0] rin;
    logic [DV_DEN_W-1:0] din;
    logic [DV_Q_W-1:0]   lin;
    logic [DV_Q_W-1:0]   qin;
    logic [DV_DEN_W:0]   cur;
    for (int k = 0; k < DV_STAGES; k++) begin
      if (k == 0) begin
        rin = num_i[DV_NUM_W-1:DV_Q_W];
        lin = num_i[DV_Q_W-1:0];
        din = den_i;
        qin = '0;
      end else begin
        rin = rem_q[k-1];
        lin = low_q[k-1];
        din = den_q[k-1];
        qin = quo_q[k-1];
      end
      cur = {rin, lin[DV_Q_W-1]};
      if (cur >= {1'b0, din}) begin
        rem_d[k] = DV_DEN_W'(cur - {1'b0, din});
        quo_d[k] = {qin[DV_Q_W-2:0], 1'b1};
      end else begin
        rem_d[k] = cur[DV_DEN_W-1:0];
        quo_d[k] = {qin[DV_Q_W-2:0], 1'b0};
      end
      low_d[k] = lin << 1;
      den_d[k] = din;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DV_STAGES; k++) begin
        rem_q[k] <= rem_d[k];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_d[k];
      end
    end
  end

  assign quo_o = quo_q[DV_STAGES-1];

endmodule

@@ rtl/refraction_direction.sv @@
// throughput: one word per cycle while the output is not stalled;
//   the depth is set by three 18-stage square-root steps and two
//   15-stage divider steps on the critical chain
// a stalled output freezes the whole pipeline, nothing is dropped
// reset clears the valid bits only; data registers are not reset
module refraction_direction (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  refr_pkg::refr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output refr_pkg::refr_out_t out_data_o
);
  import refr_pkg::*;

  localparam int LAT = 6 + SQ_STAGES + 2 + DV_STAGES + 2 + SQ_STAGES + 4
                       + SQ_STAGES + 1 + DV_STAGES + 1;

  typedef struct packed {
    logic [2:0][17:0] v;
    logic [2:0][15:0] n;
    logic [IDX_W-1:0] ni;
    logic [IDX_W-1:0] nt;
    logic             vz;
  } sb_b_t;

  typedef struct packed {
    logic [2:0][15:0] n;
    logic             vz;
    logic             tir;
    logic [2:0]       tneg;
  } sb_d_t;

  typedef struct packed {
    logic [2:0][15:0] th;
    logic [14:0]      sint;
    logic [2:0][15:0] n;
    logic             vz;
    logic             tir;
  } sb_g_t;

  typedef struct packed {
    logic [2:0][17:0] r;
    logic [2:0][15:0] n;
    logic             vz;
    logic             tir;
    logic             rz;
  } sb_j_t;

  typedef struct packed {
    logic [2:0]       rneg;
    logic [2:0][15:0] n;
    logic             vz;
    logic             tir;
    logic             rz;
  } sb_l_t;

  logic           adv;
  logic [LAT-1:0] vld_q;

  // global advance: move when the output register is free or being taken
  assign adv         = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // front stages
  logic signed [31:0] a1_p_q [3];
  logic signed [15:0] a1_d_q [3], a1_n_q [3];
  logic [IDX_W-1:0]   a1_ni_q, a1_nt_q;
  logic signed [15:0] a2_cosi_q;
  logic signed [15:0] a2_d_q [3], a2_n_q [3];
  logic [IDX_W-1:0]   a2_ni_q, a2_nt_q;
  logic [28:0]        a3_c2_q;
  logic signed [31:0] a3_nc_q [3];
  logic signed [15:0] a3_d_q [3], a3_n_q [3];
  logic [IDX_W-1:0]   a3_ni_q, a3_nt_q;
  logic [35:0]        a4_rad_q;
  logic signed [17:0] a4_v_q [3];
  logic signed [15:0] a4_n_q [3];
  logic [IDX_W-1:0]   a4_ni_q, a4_nt_q;
  logic [33:0]        a5_vs_q [3];
  logic [35:0]        a5_rad_q;
  logic signed [17:0] a5_v_q [3];
  logic signed [15:0] a5_n_q [3];
  logic [IDX_W-1:0]   a5_ni_q, a5_nt_q;
  logic [35:0]        a6_rad_q, a6_vsq_q;
  sb_b_t              a6_sb_q;

  logic signed [15:0] in_d [3], in_n [3];
  logic [IDX_W-1:0]   in_nt;
  logic signed [39:0] a2_cs;
  logic signed [15:0] a2_cosi_d;
  logic signed [17:0] a4_v_d [3];
  logic [35:0]        a6_vsq_d;

  always_comb begin
    logic signed [33:0] dot;
    in_d[0] = in_data_i.dir_x;
    in_d[1] = in_data_i.dir_y;
    in_d[2] = in_data_i.dir_z;
    in_n[0] = in_data_i.norm_x;
    in_n[1] = in_data_i.norm_y;
    in_n[2] = in_data_i.norm_z;
    in_nt   = (in_data_i.index_transmit == '0) ? IDX_W'(1) : in_data_i.index_transmit;
    // cos of incidence, clamped to plus or minus one
    dot   = 34'(a1_p_q[0]) + 34'(a1_p_q[1]) + 34'(a1_p_q[2]);
    a2_cs = rnd_shr(40'(-dot));
    if (a2_cs > 40'(ONE)) begin
      a2_cosi_d = 16'(ONE);
    end else if (a2_cs < -40'(ONE)) begin
      a2_cosi_d = -16'(ONE);
    end else begin
      a2_cosi_d = 16'(a2_cs);
    end
    // tangent part d + n cos_i
    for (int i = 0; i < 3; i++) begin
      a4_v_d[i] = 18'(a3_d_q[i]) + 18'(rnd_shr(40'(a3_nc_q[i])));
    end
    a6_vsq_d = 36'(a5_vs_q[0]) + 36'(a5_vs_q[1]) + 36'(a5_vs_q[2]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a1_p_q[i]  <= in_n[i] * in_d[i];
        a1_d_q[i]  <= in_d[i];
        a1_n_q[i]  <= in_n[i];
        a2_d_q[i]  <= a1_d_q[i];
        a2_n_q[i]  <= a1_n_q[i];
        a3_nc_q[i] <= a2_n_q[i] * a2_cosi_q;
        a3_d_q[i]  <= a2_d_q[i];
        a3_n_q[i]  <= a2_n_q[i];
        a4_v_q[i]  <= a4_v_d[i];
        a4_n_q[i]  <= a3_n_q[i];
        a5_vs_q[i] <= 34'(a4_v_q[i] * a4_v_q[i]);
        a5_v_q[i]  <= a4_v_q[i];
        a5_n_q[i]  <= a4_n_q[i];
        a6_sb_q.v[i] <= a5_v_q[i];
        a6_sb_q.n[i] <= a5_n_q[i];
      end
      a1_ni_q   <= in_data_i.index_incident;
      a1_nt_q   <= in_nt;
      a2_cosi_q <= a2_cosi_d;
      a2_ni_q   <= a1_ni_q;
      a2_nt_q   <= a1_nt_q;
      a3_c2_q   <= 29'(a2_cosi_q * a2_cosi_q);
      a3_ni_q   <= a2_ni_q;
      a3_nt_q   <= a2_nt_q;
      a4_rad_q  <= ONE2 - 36'(a3_c2_q);
      a4_ni_q   <= a3_ni_q;
      a4_nt_q   <= a3_nt_q;
      a5_rad_q  <= a4_rad_q;
      a5_ni_q   <= a4_ni_q;
      a5_nt_q   <= a4_nt_q;
      a6_rad_q  <= a5_rad_q;
      a6_vsq_q  <= a6_vsq_d;
      a6_sb_q.ni <= a5_ni_q;
      a6_sb_q.nt <= a5_nt_q;
      a6_sb_q.vz <= (a6_vsq_d == '0);
    end
  end

  // sin of incidence and tangent length
  logic [SQ_OUT_W-1:0] sini_w, vlen_w;
  sb_b_t               sb_b_q [SQ_STAGES];

  refr_isqrt u_sq_sin (.clk_i, .en_i(adv), .val_i(a6_rad_q), .root_o(sini_w));
  refr_isqrt u_sq_vlen (.clk_i, .en_i(adv), .val_i(a6_vsq_q), .root_o(vlen_w));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_b_q[0] <= a6_sb_q;
      for (int k = 1; k < SQ_STAGES; k++) begin
        sb_b_q[k] <= sb_b_q[k-1];
      end
    end
  end

  // numerators for sin_t and the normalized tangent
  sb_b_t               b_out;
  logic [28:0]         c1_sn_q, c1_lim_q;
  logic [IDX_W-1:0]    c1_nt_q;
  logic [DV_NUM_W-1:0] c1_tn_q [3];
  logic [2:0]          c1_tneg_q;
  logic [17:0]         c1_vlen_q;
  logic [2:0][15:0]    c1_n_q;
  logic                c1_vz_q;
  logic [DV_NUM_W-1:0] c2_snum_q;
  logic                c2_tir_q;
  logic [IDX_W-1:0]    c2_nt_q;
  logic [DV_NUM_W-1:0] c2_tn_q [3];
  logic [2:0]          c2_tneg_q;
  logic [17:0]         c2_vlen_q;
  logic [2:0][15:0]    c2_n_q;
  logic                c2_vz_q;
  logic [DV_NUM_W-1:0] c1_tn_d [3];
  logic [DV_NUM_W-1:0] c2_snum_d;

  assign b_out = sb_b_q[SQ_STAGES-1];

  always_comb begin
    logic signed [17:0] v;
    logic [17:0]        absv;
    for (int i = 0; i < 3; i++) begin
      v    = $signed(b_out.v[i]);
      absv = v[17] ? 18'(-v) : 18'(v);
      c1_tn_d[i] = (DV_NUM_W'(absv) << VEC_FRAC_BITS) + DV_NUM_W'(vlen_w >> 1);
    end
    c2_snum_d = DV_NUM_W'(c1_sn_q) + DV_NUM_W'(c1_nt_q >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_sn_q   <= 29'(sini_w) * 29'(b_out.ni);
      c1_lim_q  <= 29'(ONE + 1) * 29'(b_out.nt);
      c1_nt_q   <= b_out.nt;
      c1_vlen_q <= vlen_w;
      c1_n_q    <= b_out.n;
      c1_vz_q   <= b_out.vz;
      for (int i = 0; i < 3; i++) begin
        c1_tn_q[i]   <= c1_tn_d[i];
        c1_tneg_q[i] <= b_out.v[i][17];
        c2_tn_q[i]   <= c1_tn_q[i];
      end
      c2_snum_q <= c2_snum_d;
      c2_tir_q  <= (c2_snum_d >= DV_NUM_W'(c1_lim_q));
      c2_nt_q   <= c1_nt_q;
      c2_tneg_q <= c1_tneg_q;
      c2_vlen_q <= c1_vlen_q;
      c2_n_q    <= c1_n_q;
      c2_vz_q   <= c1_vz_q;
    end
  end

  // sin_t and the three tangent components
  logic [DV_Q_W-1:0] sint_w;
  logic [DV_Q_W-1:0] th_w [3];
  sb_d_t             sb_d_q [DV_STAGES];
  sb_d_t             sb_d_in;

  refr_div u_dv_sint (
    .clk_i, .en_i(adv), .num_i(c2_snum_q), .den_i(DV_DEN_W'(c2_nt_q)), .quo_o(sint_w)
  );

  for (genvar g = 0; g < 3; g++) begin : g_th
    refr_div u_dv_th (
      .clk_i, .en_i(adv), .num_i(c2_tn_q[g]), .den_i(c2_vlen_q), .quo_o(th_w[g])
    );
  end

  assign sb_d_in = '{n: c2_n_q, vz: c2_vz_q, tir: c2_tir_q, tneg: c2_tneg_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_d_q[0] <= sb_d_in;
      for (int k = 1; k < DV_STAGES; k++) begin
        sb_d_q[k] <= sb_d_q[k-1];
      end
    end
  end

  // cos_t radicand
  sb_d_t            d_out;
  logic [29:0]      e1_ss_q;
  sb_g_t            e1_sb_q, e2_sb_q;
  logic [35:0]      e2_rad_q;

  assign d_out = sb_d_q[DV_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_ss_q <= 30'(sint_w) * 30'(sint_w);
      for (int i = 0; i < 3; i++) begin
        e1_sb_q.th[i] <= d_out.tneg[i] ? 16'(-$signed({1'b0, th_w[i]}))
                                       : 16'($signed({1'b0, th_w[i]}));
      end
      e1_sb_q.sint <= sint_w;
      e1_sb_q.n    <= d_out.n;
      e1_sb_q.vz   <= d_out.vz;
      e1_sb_q.tir  <= d_out.tir;
      e2_rad_q     <= ONE2 - 36'(e1_ss_q);
      e2_sb_q      <= e1_sb_q;
    end
  end

  // cos_t
  logic [SQ_OUT_W-1:0] cost_w;
  sb_g_t               sb_g_q [SQ_STAGES];

  refr_isqrt u_sq_cos (.clk_i, .en_i(adv), .val_i(e2_rad_q), .root_o(cost_w));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_g_q[0] <= e2_sb_q;
      for (int k = 1; k < SQ_STAGES; k++) begin
        sb_g_q[k] <= sb_g_q[k-1];
      end
    end
  end

  // unnormalized refracted vector and its squared length
  sb_g_t              g_out;
  logic signed [31:0] h1_a_q [3], h1_b_q [3];
  logic signed [17:0] h2_r_q [3], h3_r_q [3];
  logic [33:0]        h3_rs_q [3];
  logic [35:0]        h4_rsq_d;
  sb_j_t              h4_sb_q;
  logic [35:0]        h4_rsq_q;
  logic [2:0][15:0]   h1_n_q, h2_n_q, h3_n_q;
  logic [1:0]         h1_f_q, h2_f_q, h3_f_q;

  assign g_out    = sb_g_q[SQ_STAGES-1];
  assign h4_rsq_d = 36'(h3_rs_q[0]) + 36'(h3_rs_q[1]) + 36'(h3_rs_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        h1_a_q[i]  <= $signed(g_out.th[i]) * $signed({1'b0, g_out.sint});
        h1_b_q[i]  <= $signed(g_out.n[i]) * $signed({1'b0, cost_w[14:0]});
        h2_r_q[i]  <= 18'(rnd_shr(40'(h1_a_q[i]))) - 18'(rnd_shr(40'(h1_b_q[i])));
        h3_rs_q[i] <= 34'(h2_r_q[i] * h2_r_q[i]);
        h3_r_q[i]  <= h2_r_q[i];
        h4_sb_q.r[i] <= h3_r_q[i];
      end
      h1_n_q <= g_out.n;
      h1_f_q <= {g_out.vz, g_out.tir};
      h2_n_q <= h1_n_q;
      h2_f_q <= h1_f_q;
      h3_n_q <= h2_n_q;
      h3_f_q <= h2_f_q;
      h4_sb_q.n   <= h3_n_q;
      h4_sb_q.vz  <= h3_f_q[1];
      h4_sb_q.tir <= h3_f_q[0];
      h4_sb_q.rz  <= (h4_rsq_d == '0);
      h4_rsq_q    <= h4_rsq_d;
    end
  end

  // length of the refracted vector
  logic [SQ_OUT_W-1:0] rlen_w;
  sb_j_t               sb_j_q [SQ_STAGES];

  refr_isqrt u_sq_rlen (.clk_i, .en_i(adv), .val_i(h4_rsq_q), .root_o(rlen_w));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_j_q[0] <= h4_sb_q;
      for (int k = 1; k < SQ_STAGES; k++) begin
        sb_j_q[k] <= sb_j_q[k-1];
      end
    end
  end

  // numerators for the final normalize
  sb_j_t               j_out;
  logic [DV_NUM_W-1:0] k1_on_q [3];
  logic [DV_NUM_W-1:0] k1_on_d [3];
  logic [17:0]         k1_rlen_q;
  sb_l_t               k1_sb_q;

  assign j_out = sb_j_q[SQ_STAGES-1];

  always_comb begin
    logic signed [17:0] r;
    logic [17:0]        absr;
    for (int i = 0; i < 3; i++) begin
      r    = $signed(j_out.r[i]);
      absr = r[17] ? 18'(-r) : 18'(r);
      k1_on_d[i] = (DV_NUM_W'(absr) << VEC_FRAC_BITS) + DV_NUM_W'(rlen_w >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        k1_on_q[i]      <= k1_on_d[i];
        k1_sb_q.rneg[i] <= j_out.r[i][17];
      end
      k1_rlen_q   <= rlen_w;
      k1_sb_q.n   <= j_out.n;
      k1_sb_q.vz  <= j_out.vz;
      k1_sb_q.tir <= j_out.tir;
      k1_sb_q.rz  <= j_out.rz;
    end
  end

  // final normalize
  logic [DV_Q_W-1:0] oq_w [3];
  sb_l_t             sb_l_q [DV_STAGES];

  for (genvar g = 0; g < 3; g++) begin : g_out_div
    refr_div u_dv_out (
      .clk_i, .en_i(adv), .num_i(k1_on_q[g]), .den_i(k1_rlen_q), .quo_o(oq_w[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_l_q[0] <= k1_sb_q;
      for (int k = 1; k < DV_STAGES; k++) begin
        sb_l_q[k] <= sb_l_q[k-1];
      end
    end
  end

  // output word: special cases first, then the normalized vector
  sb_l_t              l_out;
  logic signed [15:0] res [3];
  logic               res_tir;
  refr_out_t          out_q;

  assign l_out = sb_l_q[DV_STAGES-1];

  always_comb begin
    logic signed [15:0] q;
    res_tir = 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = $signed({1'b0, oq_w[i]});
      if (l_out.tir) begin
        res[i] = '0;
      end else if (l_out.vz) begin
        res[i] = sat16(-20'($signed(l_out.n[i])));
      end else if (l_out.rz) begin
        res[i] = '0;
      end else begin
        res[i] = l_out.rneg[i] ? -q : q;
      end
    end
    if (l_out.tir) begin
      res_tir = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.out_x         <= res[0];
      out_q.out_y         <= res[1];
      out_q.out_z         <= res[2];
      out_q.total_reflect <= res_tir;
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/refr_chk.sv @@
module refr_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input refr_pkg::refr_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input refr_pkg::refr_out_t out_data_o
);
  import refr_pkg::*;

  // a waiting output word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // a waiting output word keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // input side is open exactly when the output stage can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stage");

  // total internal reflection always comes with a zero vector
  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.total_reflect |->
      out_data_o.out_x == '0 && out_data_o.out_y == '0 && out_data_o.out_z == '0)
    else $error("reflection flag with nonzero vector");

endmodule

bind refraction_direction refr_chk u_refr_chk (.*);

@@ tb/refr_checker.sv @@
module refr_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  refr_pkg::refr_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  refr_pkg::refr_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import refr_pkg::*;

  refr_out_t expected_dirs[$];

  function automatic longint round_shift(longint x);
    longint m;
    m = ((x < 0 ? -x : x) + (64'sd1 << (VEC_FRAC_BITS - 1))) >>> VEC_FRAC_BITS;
    return x < 0 ? -m : m;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint m;
    m = ((num < 0 ? -num : num) + den / 2) / den;
    return num < 0 ? -m : m;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 <<< 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clamp16(longint x);
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    return x[15:0];
  endfunction

  // snell refraction of one incoming word
  function automatic refr_out_t refract(refr_in_t w);
    refr_out_t o;
    longint d[3], n[3], v[3], r[3];
    longint one, one2, ni, nt, dot, cosi, sini, sint, cost, vsq, vlen, rsq, rlen, th;
    one = 64'sd1 << VEC_FRAC_BITS;
    one2 = 64'sd1 << (2 * VEC_FRAC_BITS);
    d[0] = w.dir_x; d[1] = w.dir_y; d[2] = w.dir_z;
    n[0] = w.norm_x; n[1] = w.norm_y; n[2] = w.norm_z;
    ni = w.index_incident;
    nt = w.index_transmit;
    if (nt == 0) nt = 1;
    o = '0;
    dot = n[0] * d[0] + n[1] * d[1] + n[2] * d[2];
    cosi = round_shift(-dot);
    if (cosi > one) cosi = one;
    if (cosi < -one) cosi = -one;
    sini = floor_sqrt(one2 - cosi * cosi);
    sint = (sini * ni + nt / 2) / nt;
    if (sint > one) begin
      o.total_reflect = 1'b1;
      return o;
    end
    cost = floor_sqrt(one2 - sint * sint);
    vsq = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = d[i] + round_shift(n[i] * cosi);
      vsq += v[i] * v[i];
    end
    // normal incidence gives the negated normal
    if (vsq == 0) begin
      o.out_x = clamp16(-n[0]); o.out_y = clamp16(-n[1]); o.out_z = clamp16(-n[2]);
      return o;
    end
    vlen = floor_sqrt(vsq);
    rsq = 0;
    for (int i = 0; i < 3; i++) begin
      th = round_div(v[i] * one, vlen);
      r[i] = round_shift(th * sint) - round_shift(n[i] * cost);
      rsq += r[i] * r[i];
    end
    if (rsq == 0) return o;
    rlen = floor_sqrt(rsq);
    o.out_x = clamp16(round_div(r[0] * one, rlen));
    o.out_y = clamp16(round_div(r[1] * one, rlen));
    o.out_z = clamp16(round_div(r[2] * one, rlen));
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;
  assign pending_o = expected_dirs.size();

  // predict on input words, compare on output words
  always @(posedge clk_i) begin
    refr_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) expected_dirs.push_back(refract(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_dirs.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_dirs.pop_front();
          if (out_data_i.out_x !== want.out_x)
            report_mismatch("out_x", out_data_i.out_x, want.out_x);
          if (out_data_i.out_y !== want.out_y)
            report_mismatch("out_y", out_data_i.out_y, want.out_y);
          if (out_data_i.out_z !== want.out_z)
            report_mismatch("out_z", out_data_i.out_z, want.out_z);
          if (out_data_i.total_reflect !== want.total_reflect)
            report_mismatch("total_reflect", out_data_i.total_reflect, want.total_reflect);
        end
      end
    end
  end
endmodule

@@ tb/tb_refraction_direction.sv @@
module tb_refraction_direction;
  import refr_pkg::*;

  localparam int LATENCY = 100;
  localparam int WATCHDOG_LIMIT = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  refr_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  refr_out_t out_data_o;
  int        fail_count, pending;
  int        send_idle = 0, recv_idle = 0;
  bit        recv_hold = 0;
  int        idle_cycles = 0;

  always #1 clk_i = ~clk_i;

  refraction_direction DUT (.*);

  refr_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic signed [15:0] rand_comp();
    int s;
    s = $urandom_range(9);
    if (s == 0) return 16'($urandom);
    if (s == 1) return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  // random word: mostly roughly unit vectors, some raw noise
  function automatic refr_in_t rand_word();
    refr_in_t w;
    int ax, sgn;
    w.dir_x = rand_comp(); w.dir_y = rand_comp(); w.dir_z = rand_comp();
    w.norm_x = rand_comp(); w.norm_y = rand_comp(); w.norm_z = rand_comp();
    if ($urandom_range(3) != 0) begin
      // axis normal, with dir_z set against the sign of the normal
      ax = $urandom_range(2);
      sgn = $urandom_range(1) ? 1 : -1;
      w.norm_x = ax == 0 ? 16'(sgn * 16384) : 16'sd0;
      w.norm_y = ax == 1 ? 16'(sgn * 16384) : 16'sd0;
      w.norm_z = ax == 2 ? 16'(sgn * 16384) : 16'sd0;
      w.dir_z = 16'($signed($urandom_range(16384)) * -sgn);
    end
    w.index_incident = $urandom_range(7) == 0 ? 14'($urandom) : 14'($urandom_range(16383, 4096));
    w.index_transmit = $urandom_range(7) == 0 ? 14'($urandom) : 14'($urandom_range(16383, 4096));
    return w;
  endfunction

  // offer one word and wait for it to be taken; valid drops only in idle gaps
  task automatic send_word(refr_in_t w);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_vec(int dx, int dy, int dz, int nx, int ny, int nz, int ii, int it);
    refr_in_t w;
    w.dir_x = 16'(dx); w.dir_y = 16'(dy); w.dir_z = 16'(dz);
    w.norm_x = 16'(nx); w.norm_y = 16'(ny); w.norm_z = 16'(nz);
    w.index_incident = 14'(ii); w.index_transmit = 14'(it);
    send_word(w);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= !recv_hold && !(recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: extremes, normal incidence, total reflection, grazing, noise
    send_vec(0, 0, -16384, 0, 0, 16384, 4096, 4096);
    send_vec(0, 0, -16384, 0, 0, 16384, 16383, 4096);
    send_vec(11585, 0, -11585, 0, 0, 16384, 4096, 6144);
    send_vec(11585, 0, -11585, 0, 0, 16384, 6144, 4096);
    send_vec(15000, 0, -6000, 0, 0, 16384, 16383, 4096);
    send_vec(16384, 0, 0, 0, 0, 16384, 4096, 4096);
    send_vec(-16384, -16384, -16384, -16384, -16384, -16384, 4096, 0);
    send_vec(-32768, -32768, -32768, -32768, 32767, -32768, 0, 16383);
    send_vec(32767, 32767, 32767, 32767, 32767, 32767, 16383, 16383);
    send_vec(0, 0, 0, 0, 0, 0, 8192, 8192);
    send_vec(0, 0, 0, -32768, -32768, -32768, 4096, 4096);
    send_vec(0, 9459, -13377, 0, 0, 16384, 8192, 4096);
    send_vec(0, 11585, -11585, 0, 0, 16384, 5793, 4096);
    send_vec(-9459, 9459, -9459, 0, 16384, 0, 12000, 5000);
    send_vec(5000, -3000, 15000, -16384, 0, 0, 4096, 16383);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 56 : 31) : 0;
      recv_idle = (ph == 2 || ph == 3) ? (ph == 2 ? 56 : 31) : 0;
      for (int k = 0; k < 400; k++) send_word(rand_word());
      drain();
    end
    // long receiver hold so the pipeline fills and backs up
    send_idle = 0; recv_idle = 0;
    recv_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        recv_hold = 0;
      end
      for (int k = 0; k < 200; k++) send_word(rand_word());
    join
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/refr_pkg.sv
rtl/refr_isqrt.sv
rtl/refr_div.sv
rtl/refraction_direction.sv
rtl/refr_chk.sv
tb/refr_checker.sv
tb/tb_refraction_direction.sv
